[src/ffck_pkg.sv]
// Shared types and constants for the keypad calculator.
package ffck_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int IN_BITS   = 8;
  localparam int OUT_BITS  = 2 * WORD_BITS + 1;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;
  localparam int DEC_BASE  = 10;

  localparam logic [1:0] CMD_DIGIT = 2'd0;
  localparam logic [1:0] CMD_OPER  = 2'd1;
  localparam logic [1:0] CMD_EQUAL = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NONE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KEY_DIGIT,
    KEY_OPER,
    KEY_EQUAL,
    KEY_IGNORE
  } key_kind_t;

  typedef struct packed {
    key_kind_t   kind;
    logic [3:0]  digit;
    op_t         op;
  } key_item_t;

  typedef struct packed {
    logic                 start;
    logic [WORD_BITS-1:0] dividend;
    logic [WORD_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

[src/ffck_front.sv]
// Key intake stage: accepts key beats and classifies them.
module ffck_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [ffck_pkg::IN_BITS-1:0] s_tdata,
  output logic                         push,
  output ffck_pkg::key_item_t          push_item,
  input  logic                         push_ready
);
  import ffck_pkg::*;

  logic       held;
  key_item_t  item;
  key_item_t  item_next;
  logic [1:0] cmd;
  logic [3:0] dig;

  assign cmd = s_tdata[1:0];
  assign dig = s_tdata[5:2];

  always_comb begin
    item_next.digit = dig;
    item_next.op    = op_t'({1'b0, s_tdata[7:6]});
    case (cmd)
      CMD_DIGIT: item_next.kind = (dig <= 4'd9) ? KEY_DIGIT : KEY_IGNORE;
      CMD_OPER:  item_next.kind = KEY_OPER;
      CMD_EQUAL: item_next.kind = KEY_EQUAL;
      default:   item_next.kind = KEY_IGNORE;
    endcase
  end

  assign s_tready  = !held || push_ready;
  assign push      = held;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

[src/ffck_queue.sv]
// Two-entry queue of classified keys between intake and execution.
module ffck_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ffck_pkg::key_item_t push_item,
  output logic                push_ready,
  input  logic                pop,
  output ffck_pkg::key_item_t pop_item,
  output logic                pop_valid
);
  import ffck_pkg::*;

  key_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

[src/ffck_divider.sv]
// Radix-2 restoring signed divider, one quotient bit per cycle.
module ffck_divider (
  input  logic               clk,
  input  logic               rst,
  input  ffck_pkg::div_req_t req,
  output ffck_pkg::div_rsp_t rsp
);
  import ffck_pkg::*;

  logic                 busy;
  logic                 done;
  logic                 neg;
  logic [CNT_BITS-1:0]  cnt;
  logic [WORD_BITS-1:0] quo;
  logic [WORD_BITS-1:0] dvs;
  logic [WORD_BITS:0]   rem;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;

  assign mag_a   = req.dividend[WORD_BITS-1] ? -req.dividend : req.dividend;
  assign mag_b   = req.divisor[WORD_BITS-1]  ? -req.divisor  : req.divisor;
  assign shifted = {rem[WORD_BITS-1:0], quo[WORD_BITS-1]};
  assign diff    = shifted - {1'b0, dvs};

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
    if (req.start) begin
      rem <= '0;
      quo <= mag_a;
      dvs <= mag_b;
      neg <= req.dividend[WORD_BITS-1] ^ req.divisor[WORD_BITS-1];
      cnt <= CNT_BITS'(WORD_BITS - 1);
    end else if (busy) begin
      if (!diff[WORD_BITS]) begin
        rem <= diff;
        quo <= {quo[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[WORD_BITS-2:0], 1'b0};
      end
      cnt <= cnt - CNT_BITS'(1);
    end
  end

endmodule

[src/ffck_back.sv]
// Execution stage: operand state, arithmetic and the result register.
module ffck_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  input  ffck_pkg::key_item_t            pop_item,
  output logic                           pop,
  output ffck_pkg::div_req_t             div_req,
  input  ffck_pkg::div_rsp_t             div_rsp,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ffck_pkg::OUT_TDATA-1:0] m_tdata
);
  import ffck_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t               state;
  logic [WORD_BITS-1:0] first;
  logic [WORD_BITS-1:0] second;
  logic                 first_entered;
  logic                 second_entered;
  op_t                  pending;
  logic [WORD_BITS-1:0] shown;
  logic                 err;
  logic                 out_valid;
  logic [WORD_BITS-1:0] entry;
  logic [WORD_BITS-1:0] target;
  logic [WORD_BITS-1:0] appended;
  logic [WORD_BITS-1:0] sum;
  logic [WORD_BITS-1:0] dif;
  logic [WORD_BITS-1:0] prod;
  logic                 calc;

  assign pop      = (state == S_IDLE) && pop_valid && (!out_valid || m_tready);
  assign target   = (pending == OP_NONE) ? first : second;
  assign appended = (target << 3) + (target << 1) + WORD_BITS'(pop_item.digit);
  assign sum      = first + second;
  assign dif      = first - second;
  assign prod     = first * second;
  assign calc     = (first != '0) && (pending != OP_NONE);

  assign div_req.start    = pop && (pop_item.kind == KEY_EQUAL) && calc
                            && (pending == OP_DIV) && (second != '0);
  assign div_req.dividend = first;
  assign div_req.divisor  = second;

  assign entry    = (pending == OP_NONE) ? first : second;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_TDATA - OUT_BITS){1'b0}}, err, entry, shown};

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      first          <= '0;
      second         <= '0;
      first_entered  <= 1'b0;
      second_entered <= 1'b0;
      pending        <= OP_NONE;
      shown          <= '0;
      err            <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop) begin
            err       <= 1'b0;
            out_valid <= !div_req.start;
            case (pop_item.kind)
              KEY_DIGIT: begin
                if (pending == OP_NONE) begin
                  first         <= appended;
                  first_entered <= 1'b1;
                end else begin
                  second         <= appended;
                  second_entered <= 1'b1;
                end
              end
              KEY_OPER: begin
                pending <= pop_item.op;
              end
              KEY_EQUAL: begin
                first_entered  <= 1'b0;
                second_entered <= 1'b0;
                second         <= '0;
                if (calc) begin
                  case (pending)
                    OP_ADD: begin
                      first <= sum;
                      shown <= sum;
                    end
                    OP_SUB: begin
                      first <= dif;
                      shown <= dif;
                    end
                    OP_MUL: begin
                      first <= prod;
                      shown <= prod;
                    end
                    default: begin
                      if (second == '0) begin
                        err <= 1'b1;
                      end else begin
                        state <= S_DIV;
                      end
                    end
                  endcase
                end else if (!first_entered && second_entered) begin
                  first <= second;
                  shown <= second;
                end
              end
              default: begin
              end
            endcase
          end else if (m_tready) begin
            out_valid <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            first     <= div_rsp.quotient;
            shown     <= div_rsp.quotient;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/four_function_calculator_keypad.sv]
// Top level of the four-function keypad calculator.
//
// Input channel s_*: one key per beat. Output channel m_*: one result per key.
// Each key beat gives exactly one result beat, in order.
// On its way to a result, an accepted key lands in the intake register, moves
// into the queue, then into the result register. An equals key that starts a
// divide waits for the quotient from a radix-2 divider that retires one bit
// per cycle. Throughput: one key per cycle while results drain; a divide
// holds the execution stage while intake fills the two-entry queue.
// When the receiver holds m_tready low, the result beat stays put, execution
// stops, the queue fills and then s_tready falls.
// Reset clears both operands, the entered marks, the display and the pending
// operator (none selected), and empties the queue and result register.
module four_function_calculator_keypad (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // command[1:0], digit[5:2], operation[7:6]
  input  logic [ffck_pkg::IN_BITS-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // display_value[31:0], entry_value[63:32], divide_error[64], zero pad
  output logic [ffck_pkg::OUT_TDATA-1:0] m_tdata
);
  import ffck_pkg::*;

  logic      push;
  logic      push_ready;
  key_item_t push_item;
  logic      pop;
  logic      pop_valid;
  key_item_t pop_item;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  ffck_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  ffck_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_item   (pop_item),
    .pop_valid  (pop_valid)
  );

  ffck_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ffck_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[src/ffck_checker.sv]
// Port-level checks for the keypad calculator, bound to the top level.
module ffck_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ffck_pkg::OUT_TDATA-1:0] m_tdata
);
  import ffck_pkg::*;

  logic [OUT_TDATA-1:0] pad_mask;

  assign pad_mask = {{(OUT_TDATA - OUT_BITS){1'b1}}, {OUT_BITS{1'b0}}};

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata & pad_mask) == '0))
    else $error("result padding not zero");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_no_early_result: assert property (@(posedge clk)
    rst ##1 !(s_tvalid && s_tready) |=> !m_tvalid)
    else $error("result without a key");

endmodule

bind four_function_calculator_keypad ffck_checker u_ffck_checker (.*);
